// File: rtl/core/astc_pkg.sv
// ----------------------------------------------------------------------------
// astc_pkg: shared types and constants for the aligned section table builder
// Holds the item kind codes, field widths, CRC-32 constants and the
// byte-wise reflected CRC-32 update.
// ----------------------------------------------------------------------------
package astc_pkg;

    localparam int ASTC_ALIGN_BYTES = 64;

    localparam int HDR_W  = 16;
    localparam int LEN_W  = 40;
    localparam int OFS_W  = 48;
    localparam int CRC_W  = 32;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd2;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};

    // One item as seen by the state-holding units
    typedef struct packed {
        logic              go;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
    } t_step;

    // Running per-section status
    typedef struct packed {
        logic [CRC_W-1:0] crc;
        logic [LEN_W-1:0] count;
        logic             ovf;
    } t_sec_status;

    // Reflected CRC-32, one byte, LSB first
    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] c,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] x;
        x = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// File: rtl/core/astc_if.sv
// ----------------------------------------------------------------------------
// astc_if: valid/ready channels of the aligned section table builder
// Item input, section entry output and the configuration write channel.
// ----------------------------------------------------------------------------
interface astc_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] sec_id;

    modport source (output valid, kind, data_byte, sec_id, input ready);
    modport sink   (input valid, kind, data_byte, sec_id, output ready);
endinterface

interface astc_entry_if;
    logic        valid;
    logic        ready;
    logic [7:0]  entry_sec_id;
    logic [47:0] entry_offset;
    logic [39:0] entry_length;
    logic [31:0] entry_checksum;
    logic [47:0] next_offset;
    logic        length_overflow;

    modport source (output valid, entry_sec_id, entry_offset, entry_length,
                    entry_checksum, next_offset, length_overflow, input ready);
    modport sink   (input valid, entry_sec_id, entry_offset, entry_length,
                    entry_checksum, next_offset, length_overflow, output ready);
endinterface

interface astc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/astc_section_acc.sv
// ----------------------------------------------------------------------------
// astc_section_acc: per-section CRC-32 and saturating length count
// Folds one data byte per step into the CRC and counts it; a close or a
// begin item restarts the section.
// ----------------------------------------------------------------------------
module astc_section_acc
    import astc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_step       i_step,
    output t_sec_status o_status
);

    logic [CRC_W-1:0] r_crc,   n_crc;
    logic [LEN_W-1:0] r_count, n_count;
    logic             r_ovf,   n_ovf;

    always_comb begin
        n_crc   = r_crc;
        n_count = r_count;
        n_ovf   = r_ovf;
        if (i_step.go) begin
            case (i_step.kind)
                KIND_DATA: begin
                    n_crc = crc32_byte(r_crc, i_step.data_byte);
                    // hold the count at its ceiling and flag it
                    if (r_count == LEN_MAX) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + {{(LEN_W-1){1'b0}}, 1'b1};
                    end
                end
                KIND_CLOSE, KIND_BEGIN: begin
                    n_crc   = CRC_INIT;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_INIT;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_crc   <= n_crc;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    assign o_status.crc   = r_crc;
    assign o_status.count = r_count;
    assign o_status.ovf   = r_ovf;

endmodule

// File: rtl/core/astc_offset_trk.sv
// ----------------------------------------------------------------------------
// astc_offset_trk: running section offset with alignment
// Computes the aligned, saturated next offset on close and reloads the
// aligned header-and-table size on begin. ALIGN_BYTES is a power of two.
// ----------------------------------------------------------------------------
module astc_offset_trk
    import astc_pkg::*;
#(
    parameter int ALIGN_BYTES = ASTC_ALIGN_BYTES
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_step            i_step,
    input  logic [HDR_W-1:0] i_header_table_bytes,
    input  logic [LEN_W-1:0] i_length,
    output logic [OFS_W-1:0] o_offset,
    output logic [OFS_W-1:0] o_next_offset
);

    localparam int ALIGN_LOG2 = $clog2(ALIGN_BYTES);
    localparam logic [OFS_W+1:0] ROUND_ADD = (OFS_W+2)'(ALIGN_BYTES - 1);
    localparam logic [HDR_W:0]   HDR_ADD   = (HDR_W+1)'(ALIGN_BYTES - 1);
    localparam logic [OFS_W-1:0] OFS_SAT   =
        {{(OFS_W-ALIGN_LOG2){1'b1}}, {ALIGN_LOG2{1'b0}}};

    logic [OFS_W-1:0] r_offset, n_offset;
    logic [OFS_W:0]   w_sum;
    logic [OFS_W+1:0] w_round;
    logic [OFS_W+1:0] w_round_al;
    logic [OFS_W-1:0] w_next;
    logic [HDR_W:0]   w_hdr_round;
    logic [OFS_W-1:0] w_hdr_al;

    always_comb begin
        w_sum      = (OFS_W+1)'(r_offset) + (OFS_W+1)'(i_length);
        w_round    = (OFS_W+2)'(w_sum) + ROUND_ADD;
        w_round_al = {w_round[OFS_W+1:ALIGN_LOG2], {ALIGN_LOG2{1'b0}}};
        // clamp to the last aligned offset below the 48-bit ceiling
        w_next     = (w_round_al[OFS_W+1:OFS_W] != 2'b00) ? OFS_SAT
                                                          : w_round_al[OFS_W-1:0];

        w_hdr_round = (HDR_W+1)'(i_header_table_bytes) + HDR_ADD;
        w_hdr_al    = OFS_W'({w_hdr_round[HDR_W:ALIGN_LOG2], {ALIGN_LOG2{1'b0}}});

        n_offset = r_offset;
        if (i_step.go) begin
            case (i_step.kind)
                KIND_CLOSE: n_offset = w_next;
                KIND_BEGIN: n_offset = w_hdr_al;
                default:    n_offset = r_offset;
            endcase
        end
    end

    // header size resets to zero, so the aligned start is zero too
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else begin
            r_offset <= n_offset;
        end
    end

    assign o_offset      = r_offset;
    assign o_next_offset = w_next;

endmodule

// File: rtl/core/aligned_section_table_crc32.sv
// ----------------------------------------------------------------------------
// aligned_section_table_crc32: section table entries with CRC-32
// Streams section bytes, keeps a reflected CRC-32 and length per section and
// emits one table entry with aligned offsets on each close request.
//
//   channel   dir  handshake     payload
//   i_cfg     in   valid/ready   data (header plus table bytes)
//   i_item    in   valid/ready   kind, data_byte, sec_id
//   o_entry   out  valid/ready   id, offset, length, checksum, next, overflow
//
// One request per cycle while no held entry stalls it: an accepted request is
// held in the input register, is applied to the CRC, length and offset state
// and, on close, lands in the output register, so an entry is presented from
// the output register after passing the input register. The 8-bit CRC update
// and the 49-bit offset add set the cycle. A held entry stalls the input
// register; the input side keeps taking requests while the entry is taken in the same cycle.
// Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module aligned_section_table_crc32
    import astc_pkg::*;
#(
    parameter int ALIGN_BYTES = ASTC_ALIGN_BYTES
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    astc_cfg_if.sink     i_cfg,
    astc_item_if.sink    i_item,
    astc_entry_if.source o_entry
);

    localparam int ALIGN_LOG2 = $clog2(ALIGN_BYTES);

    logic [HDR_W-1:0]  r_hdr_bytes;

    logic              r_in_valid;
    logic [KIND_W-1:0] r_in_kind;
    logic [BYTE_W-1:0] r_in_data;
    logic [BYTE_W-1:0] r_in_id;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_id;
    logic [OFS_W-1:0]  r_out_offset;
    logic [LEN_W-1:0]  r_out_length;
    logic [CRC_W-1:0]  r_out_crc;
    logic [OFS_W-1:0]  r_out_next;
    logic              r_out_ovf;

    logic              w_go;
    logic              w_load;
    t_step             w_step;
    t_sec_status       w_status;
    logic [OFS_W-1:0]  w_offset;
    logic [OFS_W-1:0]  w_next_offset;

    // advance the input register unless a held entry is not taken
    assign w_go   = r_in_valid && (!r_out_valid || o_entry.ready);
    assign w_load = w_go && (r_in_kind == KIND_CLOSE);

    assign i_item.ready = !r_in_valid || w_go;
    assign i_cfg.ready  = 1'b1;

    assign w_step.go        = w_go;
    assign w_step.kind      = r_in_kind;
    assign w_step.data_byte = r_in_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_bytes <= '0;
        end else if (i_cfg.valid) begin
            r_hdr_bytes <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_kind <= i_item.kind;
            r_in_data <= i_item.data_byte;
            r_in_id   <= i_item.sec_id;
        end
    end

    astc_section_acc u_section_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .o_status (w_status)
    );

    astc_offset_trk #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_offset_trk (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_step               (w_step),
        .i_header_table_bytes (r_hdr_bytes),
        .i_length             (w_status.count),
        .o_offset             (w_offset),
        .o_next_offset        (w_next_offset)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_entry.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_id     <= r_in_id;
            r_out_offset <= w_offset;
            r_out_length <= w_status.count;
            r_out_crc    <= ~w_status.crc;
            r_out_next   <= w_next_offset;
            r_out_ovf    <= w_status.ovf;
        end
    end

    assign o_entry.valid           = r_out_valid;
    assign o_entry.entry_sec_id    = r_out_id;
    assign o_entry.entry_offset    = r_out_offset;
    assign o_entry.entry_length    = r_out_length;
    assign o_entry.entry_checksum  = r_out_crc;
    assign o_entry.next_offset     = r_out_next;
    assign o_entry.length_overflow = r_out_ovf;

    a_next_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_next[ALIGN_LOG2-1:0] == '0))
        else $error("next offset not aligned");

    a_next_not_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_next >= r_out_offset))
        else $error("next offset below section offset");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> (r_out_length == LEN_MAX))
        else $error("overflow flagged without saturated length");

    a_stall_keeps_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_go) |=> r_in_valid)
        else $error("stalled request dropped");

endmodule

// File: test/aligned_section_table_crc32_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aligned_section_table_crc32_tb: section table builder testbench
// Streams section bytes, close and begin requests into the block under
// random source and sink gaps, predicts every section entry (offset, length,
// CRC-32, aligned next offset) and compares the entries as they are taken.
// ----------------------------------------------------------------------------
module aligned_section_table_crc32_tb;
    import astc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam longint unsigned ALIGN      = ASTC_ALIGN_BYTES;
    localparam longint unsigned OFS_TOP    = (64'd1 << OFS_W) - 64'd1;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 108;

    typedef struct packed {
        logic [BYTE_W-1:0] id;
        logic [OFS_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
        logic [CRC_W-1:0]  checksum;
        logic [OFS_W-1:0]  next;
        logic              ovf;
    } t_entry;

    // Tracks the layout state and the section entries still owed by the block
    class section_table_tracker;
        logic [HDR_W-1:0] header_bytes;
        logic [CRC_W-1:0] crc;
        logic [LEN_W-1:0] count;
        logic [OFS_W-1:0] offset;
        logic             saturated;
        t_entry           owed_entries[$];
        int               failures;

        function new();
            header_bytes = '0;
            failures     = 0;
            restart_section();
            offset = round_to_align('0);
        endfunction

        function void restart_section();
            crc       = CRC_INIT;
            count     = '0;
            saturated = 1'b0;
        endfunction

        // Round up to the alignment, clamp below the top of the offset range
        function logic [OFS_W-1:0] round_to_align(input logic [OFS_W+1:0] v);
            longint unsigned r;
            r = (64'(v) + ALIGN - 64'd1) / ALIGN * ALIGN;
            if (r > OFS_TOP) r = OFS_TOP / ALIGN * ALIGN;
            return r[OFS_W-1:0];
        endfunction

        function void fold_byte(input logic [BYTE_W-1:0] b);
            crc = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
            for (int n = 0; n < BYTE_W; n++) begin
                if (crc[0]) crc = (crc >> 1) ^ CRC_POLY;
                else crc = crc >> 1;
            end
        endfunction

        function void set_header(input logic [HDR_W-1:0] value);
            header_bytes = value;
        endfunction

        function void take_request(input logic [KIND_W-1:0] kind,
                                   input logic [BYTE_W-1:0] data_byte,
                                   input logic [BYTE_W-1:0] sec_id);
            t_entry e;
            case (kind)
                KIND_DATA: begin
                    fold_byte(data_byte);
                    if (count == LEN_MAX) saturated = 1'b1;
                    else count = count + 1'b1;
                end
                KIND_BEGIN: begin
                    restart_section();
                    offset = round_to_align({{(OFS_W+2-HDR_W){1'b0}}, header_bytes});
                end
                KIND_CLOSE: begin
                    e.id       = sec_id;
                    e.offset   = offset;
                    e.length   = count;
                    e.checksum = ~crc;
                    e.next     = round_to_align({2'b00, offset} +
                                                {{(OFS_W+2-LEN_W){1'b0}}, count});
                    e.ovf      = saturated;
                    owed_entries.insert(owed_entries.size(), e);
                    offset = e.next;
                    restart_section();
                end
                default: ;
            endcase
        endfunction

        function int owed();
            return owed_entries.size();
        endfunction

        function void report(input string field, input logic [63:0] want,
                             input logic [63:0] got);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                         $realtime, field, want, got);
        endfunction

        function void check_entry(input t_entry got);
            t_entry want;
            if (owed_entries.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: entry for section 0x%0h with no close request waiting",
                             $realtime, got.id);
                return;
            end
            want = owed_entries.pop_front();
            if (got.id !== want.id) report("section id", 64'(want.id), 64'(got.id));
            if (got.offset !== want.offset)
                report("offset", 64'(want.offset), 64'(got.offset));
            if (got.length !== want.length)
                report("length", 64'(want.length), 64'(got.length));
            if (got.checksum !== want.checksum)
                report("checksum", 64'(want.checksum), 64'(got.checksum));
            if (got.next !== want.next)
                report("next offset", 64'(want.next), 64'(got.next));
            if (got.ovf !== want.ovf)
                report("length overflow", 64'(want.ovf), 64'(got.ovf));
        endfunction

        function void flag_leftovers();
            if (owed_entries.size() != 0) begin
                failures += owed_entries.size();
                $display("%0d section entries never arrived", owed_entries.size());
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   calm      = 1'b0;
    bit   sink_hold = 1'b0;
    bit   hold_req  = 1'b0;
    int   sent      = 0;

    section_table_tracker ledger;

    astc_cfg_if   cfg_bus();
    astc_item_if  item_bus();
    astc_entry_if entry_bus();

    aligned_section_table_crc32 i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_item  (item_bus),
        .o_entry (entry_bus)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 70) return $urandom_range(6, 0);
        if (roll < 95) return $urandom_range(70, 7);
        return $urandom_range(160, 100);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && entry_bus.valid && entry_bus.ready)
            ledger.check_entry({entry_bus.entry_sec_id, entry_bus.entry_offset,
                                entry_bus.entry_length, entry_bus.entry_checksum,
                                entry_bus.next_offset, entry_bus.length_overflow});
    end

    initial begin : entry_sink
        int wait_left;
        wait_left = 0;
        entry_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold || wait_left > 0) begin
                entry_bus.ready <= 1'b0;
                if (wait_left > 0) wait_left--;
            end else begin
                entry_bus.ready <= 1'b1;
                wait_left = calm ? 0 : idle_gap();
            end
        end
    end

    // Hold the sink off long enough for the block to back up into its input
    initial begin : sink_pressure
        wait (hold_req);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold = 1'b0;
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b,
                             input logic [BYTE_W-1:0] sid);
        int gap;
        gap = calm ? 0 : idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.kind      <= kind;
        item_bus.data_byte <= b;
        item_bus.sec_id    <= sid;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        ledger.take_request(kind, b, sid);
        if (kind != KIND_UNUSED) sent++;
    endtask

    task automatic release_items();
        @(negedge i_clk);
        item_bus.valid <= 1'b0;
    endtask

    // Wait out every owed entry, then cover requests that give no entry
    task automatic wait_drained();
        while (ledger.owed() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_header(input logic [HDR_W-1:0] value);
        release_items();
        wait_drained();
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        ledger.set_header(value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_bytes(input int n);
        for (int k = 0; k < n; k++)
            send_item(KIND_DATA, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
    endtask

    task automatic send_section(input int n, input logic [BYTE_W-1:0] sid);
        send_bytes(n);
        send_item(KIND_CLOSE, 8'($urandom_range(255, 0)), sid);
    endtask

    initial begin : stimulus
        string check_str;
        logic [HDR_W-1:0] hdr;
        int phase;
        int stop_at;
        int roll;

        ledger = new();
        check_str = "123456789";
        item_bus.valid     = 1'b0;
        item_bus.kind      = KIND_DATA;
        item_bus.data_byte = '0;
        item_bus.sec_id    = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty section straight after reset: zero length and checksum
        send_item(KIND_CLOSE, 8'h00, 8'h00);
        // Standard check string gives the well-known CRC-32 value
        for (int k = 0; k < check_str.len(); k++)
            send_item(KIND_DATA, check_str[k], 8'h00);
        send_item(KIND_CLOSE, 8'hFF, 8'hFF);
        send_item(KIND_DATA, 8'h00, 8'hFF);
        send_item(KIND_DATA, 8'hFF, 8'h00);
        send_item(KIND_UNUSED, 8'hAA, 8'h55);
        send_item(KIND_UNUSED, 8'h55, 8'hAA);
        send_item(KIND_CLOSE, 8'h00, 8'h5A);
        send_item(KIND_BEGIN, 8'hFF, 8'hFF);
        send_item(KIND_CLOSE, 8'hFF, 8'h01);
        send_item(KIND_DATA, 8'h5A, 8'hA5);
        send_item(KIND_BEGIN, 8'h00, 8'h00);
        send_item(KIND_CLOSE, 8'h00, 8'hA5);

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: hdr = 16'hFFFF;
                1: hdr = 16'h0000;
                2: hdr = 16'd64;
                3: hdr = 16'd63;
                4: hdr = 16'd1;
                5: hdr = 16'd65;
                default: hdr = 16'($urandom_range(16'hFFFF, 0));
            endcase
            write_header(hdr);
            calm = (phase % 3 == 2);
            // Sometimes keep the old layout until a later begin picks up the size
            if (phase < 2 || $urandom_range(1, 0))
                send_item(KIND_BEGIN, 8'($urandom_range(255, 0)),
                          8'($urandom_range(255, 0)));
            if (phase == 1) begin
                hold_req = 1'b1;
                calm = 1'b1;
                for (int k = 0; k < 12; k++)
                    send_section(k % 2, 8'($urandom_range(255, 0)));
                calm = 1'b0;
            end
            stop_at = sent + PHASE_ITEMS;
            while (sent < stop_at) begin
                roll = $urandom_range(99, 0);
                if (roll < 5) begin
                    // Abandon a partial section
                    send_bytes($urandom_range(5, 0));
                    send_item(KIND_BEGIN, 8'($urandom_range(255, 0)),
                              8'($urandom_range(255, 0)));
                end else if (roll < 9) begin
                    send_item(KIND_UNUSED, 8'($urandom_range(255, 0)),
                              8'($urandom_range(255, 0)));
                end else begin
                    send_section(pick_length(), 8'($urandom_range(255, 0)));
                end
            end
        end

        calm = 1'b0;
        release_items();
        wait_drained();
        ledger.flag_leftovers();
        if (ledger.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
